### design/gru_pkg.sv
// Package for the Givens rotation unit: payload types, state codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package gru_pkg;

  typedef struct packed {
    logic              kind;
    logic [4:0]        slot;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } gru_in_t;

  typedef struct packed {
    logic signed [31:0] first_result;
    logic signed [31:0] second_result;
    logic               saturated;
  } gru_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_SQRT,
    ST_RECIP,
    ST_RT,
    ST_STORE,
    ST_MUL_A,
    ST_MUL_B,
    ST_ROUND,
    ST_OUT
  } gru_state_t;

  localparam logic        KIND_GEN   = 1'b0;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam int          DIV_STEPS  = 31;
  localparam int          SQRT_STEPS = 31;
  localparam int          RECIP_STEPS = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read_table;
    logic setup_div;
    logic step_div;
    logic setup_sqrt;
    logic step_sqrt;
    logic setup_recip;
    logic step_recip;
    logic calc_rt;
    logic store;
    logic mul_a;
    logic mul_b;
    logic round;
  } gru_cmd_t;

  typedef struct packed {
    logic kind_gen;
    logic b_zero;
  } gru_status_t;

endpackage
`default_nettype wire

### design/gru_if.sv
// Valid/ready stream interface carrying one item of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface gru_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/givens_rotation_unit.sv
// Top level of the Givens rotation unit: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. A generating item (kind 0) goes through a decode
// state, a 31-step restoring divider for t, a 31-step square root of
// 1+t^2 and a 31-step reciprocal (each of the last two after a setup step),
// then states to form the factors, store them, multiply and round. A
// generating pair whose second value is zero skips the iterations and the
// forming of factors; an applying item (kind 1) also skips the store. The
// block is ready for the next item in the cycle after each result is taken.
// The rotation table is undefined until a slot is written by a generating item.
module givens_rotation_unit #(
  parameter int SLOTS = 32
) (
  input wire clk,
  input wire rst_n,
  gru_if.sink   in_ch,
  gru_if.source out_ch
);
  import gru_pkg::*;

  gru_cmd_t    cmd;
  gru_status_t status;

  gru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gru_dp #(.SLOTS(SLOTS)) u_dp (
    .clk      (clk),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_ch.data)
  );
endmodule
`default_nettype wire

### design/gru_ctrl.sv
// Controller state machine sequencing the iterative factor generation and rotation.
`timescale 1ns / 1ps
`default_nettype none
module gru_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire gru_pkg::gru_status_t status,
  output gru_pkg::gru_cmd_t     cmd
);
  import gru_pkg::*;

  gru_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (status.kind_gen) begin
          if (status.b_zero) begin
            state_nxt = ST_STORE;
          end else begin
            cmd.setup_div = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end else begin
          cmd.read_table = 1'b1;
          state_nxt = ST_MUL_A;
        end
      end
      ST_DIV: begin
        cmd.step_div = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          cmd.setup_sqrt = 1'b1;
        end else begin
          cmd.step_sqrt = 1'b1;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RECIP;
        end
      end
      ST_RECIP: begin
        if (cnt_r == '0) begin
          cmd.setup_recip = 1'b1;
        end else begin
          cmd.step_recip = 1'b1;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(RECIP_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RT;
        end
      end
      ST_RT: begin
        cmd.calc_rt = 1'b1;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/gru_dp.sv
// Datapath: restoring divider, square root, reciprocal, rotation table and rotation MACs.
`timescale 1ns / 1ps
`default_nettype none
module gru_dp #(
  parameter int SLOTS = 32
) (
  input  wire                    clk,
  input  wire gru_pkg::gru_in_t  in_data,
  input  wire gru_pkg::gru_cmd_t cmd,
  output gru_pkg::gru_status_t   status,
  output gru_pkg::gru_out_t      out_data
);
  import gru_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [63:0] table_mem [SLOTS];

  logic              kind_r;
  logic [4:0]        slot_r;
  logic signed [31:0] a_r, b_r;
  logic              swap_r, neg_r;
  logic [31:0]       den_r;
  logic [62:0]       rem_r;      // division remainder / general shifting register
  logic [30:0]       tm_r;       // quotient, |t| in Q1.30 (up to 2^30)
  logic [62:0]       sq_v_r;
  logic [62:0]       sq_res_r;
  logic [62:0]       sq_bit_r;
  logic [31:0]       q_r;
  logic [61:0]       rc_rem_r;
  logic [31:0]       r_r;
  logic signed [31:0] c_r, s_r;
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r;
  gru_out_t          out_r;

  logic [AW-1:0] slot_addr;
  assign slot_addr = AW'(slot_r);

  logic [31:0] mag_a, mag_b;
  assign mag_a = a_r[31] ? 32'(-a_r) : 32'(a_r);
  assign mag_b = b_r[31] ? 32'(-b_r) : 32'(b_r);

  assign status.kind_gen = (kind_r == KIND_GEN);
  assign status.b_zero   = (b_r == '0);
  assign out_data        = out_r;

  // Division step: shift numerator bits in, one quotient bit a cycle.
  logic [32:0] div_trial;
  logic [32:0] div_part;
  assign div_part  = {rem_r[62:31], 1'b0} | 33'(rem_r[30]);
  assign div_trial = div_part - {1'b0, den_r};

  logic [62:0] sq_sum;
  assign sq_sum = sq_res_r + sq_bit_r;

  logic [62:0] rc_shift;
  logic [62:0] rc_trial;
  assign rc_shift = {rc_rem_r, 1'b0};
  assign rc_trial = rc_shift - 63'(q_r);

  logic [63:0] rt_prod;
  assign rt_prod = 64'(r_r) * 64'(tm_r);

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p,
                                                   output logic sat);
    logic signed [64:0] t;
    logic signed [34:0] v;
    t = 65'(p) + 65'sd536870912;
    v = t[64:30];
    sat = 1'b0;
    if (v > 35'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic signed [31:0] rx, ry;
  logic sx, sy;
  always_comb begin
    rx = round_sat(pa_r - pb_r, sx);
    ry = round_sat(pc_r + pd_r, sy);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      slot_r <= in_data.slot;
      a_r    <= in_data.first_value;
      b_r    <= in_data.second_value;
      c_r    <= $signed(ONE_Q30);
      s_r    <= '0;
    end
    if (cmd.read_table) begin
      if (32'(slot_r) < SLOTS) begin
        c_r <= table_mem[slot_addr][31:0];
        s_r <= table_mem[slot_addr][63:32];
      end else begin
        c_r <= '0;
        s_r <= '0;
      end
    end
    if (cmd.setup_div) begin
      swap_r <= (mag_a < mag_b);
      if (mag_a < mag_b) begin
        den_r <= mag_b;
        rem_r <= {1'b0, mag_a, 30'd0};
        neg_r <= (a_r != '0) && (a_r[31] == b_r[31]);
      end else begin
        den_r <= mag_a;
        rem_r <= {1'b0, mag_b, 30'd0};
        neg_r <= (b_r[31] == a_r[31]);
      end
      tm_r <= '0;
    end
    // rem_r: upper 32 bits partial remainder, lower 31 bits numerator still to shift.
    if (cmd.step_div) begin
      if (!div_trial[32]) begin
        rem_r <= {div_trial[31:0], rem_r[29:0], 1'b0};
        tm_r  <= {tm_r[29:0], 1'b1};
      end else begin
        rem_r <= {div_part[31:0], rem_r[29:0], 1'b0};
        tm_r  <= {tm_r[29:0], 1'b0};
      end
    end
    if (cmd.setup_sqrt) begin
      sq_v_r   <= (63'd1 << 60) + 63'(64'(tm_r) * 64'(tm_r));
      sq_res_r <= '0;
      sq_bit_r <= 63'd1 << 60;
    end
    if (cmd.step_sqrt) begin
      if (sq_v_r >= sq_sum) begin
        sq_v_r   <= sq_v_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.setup_recip) begin
      q_r      <= sq_res_r[31:0];
      // 2^60 / q with q in [2^30, 2^30*sqrt2): first step starts from 2^29.
      rc_rem_r <= 62'd1 << 29;
      r_r      <= '0;
    end
    if (cmd.step_recip) begin
      if (!rc_trial[62] && rc_shift >= 63'(q_r)) begin
        rc_rem_r <= rc_trial[61:0];
        r_r      <= {r_r[30:0], 1'b1};
      end else begin
        rc_rem_r <= rc_shift[61:0];
        r_r      <= {r_r[30:0], 1'b0};
      end
    end
    if (cmd.calc_rt) begin
      if (swap_r) begin
        c_r <= neg_r ? -$signed(rt_prod[61:30]) : $signed(rt_prod[61:30]);
        s_r <= $signed(r_r);
      end else begin
        c_r <= $signed(r_r);
        s_r <= neg_r ? -$signed(rt_prod[61:30]) : $signed(rt_prod[61:30]);
      end
    end
    if (cmd.store && (32'(slot_r) < SLOTS)) begin
      table_mem[slot_addr] <= {s_r, c_r};
    end
    if (cmd.mul_a) begin
      pa_r <= 64'(c_r) * 64'(a_r);
      pb_r <= 64'(s_r) * 64'(b_r);
    end
    if (cmd.mul_b) begin
      pc_r <= 64'(s_r) * 64'(a_r);
      pd_r <= 64'(c_r) * 64'(b_r);
    end
    if (cmd.round) begin
      out_r.first_result  <= rx;
      out_r.second_result <= ry;
      out_r.saturated     <= sx | sy;
    end
  end
endmodule
`default_nettype wire

### test/gru_checker.sv
// Checker for the Givens rotation unit: predicts each result and compares it.
`timescale 1ns / 1ps
module gru_checker #(
  parameter int SLOTS = 32
) (
  input  wire clk,
  input  wire rst_n,
  input  wire in_valid,
  input  wire in_ready,
  input  gru_pkg::gru_in_t in_data,
  input  wire out_valid,
  input  wire out_ready,
  input  gru_pkg::gru_out_t out_data,
  output int  fail_count,
  output int  pending
);
  import gru_pkg::*;

  logic [63:0] factor_store [SLOTS];
  gru_out_t    rotated_q[$];

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    int_sqrt = res;
  endfunction

  // Divides by 2^30 rounding half up, then clips to 32 bits.
  function automatic logic signed [31:0] round_clip(input logic signed [63:0] p,
                                                      inout logic clipped);
    logic signed [63:0] v;
    v = (p + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic gru_out_t rotate_pair(input gru_in_t item);
    logic signed [63:0] a, b, c, s, num, den;
    logic [63:0] tm, q, r, rt;
    logic neg, clipped;
    gru_out_t res;
    a = item.first_value;
    b = item.second_value;
    c = 0;
    s = 0;
    clipped = 1'b0;
    if (item.kind == KIND_GEN) begin
      if (b == 0) begin
        c = 64'sd1 <<< 30;
      end else begin
        if (abs64(a) < abs64(b)) begin
          num = a; den = b;
        end else begin
          num = b; den = a;
        end
        tm = (abs64(num) << 30) / abs64(den);
        neg = (num != 0) && ((num < 0) == (den < 0));
        q = int_sqrt((64'd1 << 60) + tm * tm);
        r = (64'd1 << 60) / q;
        rt = (r * tm) >> 30;
        if (abs64(a) < abs64(b)) begin
          c = neg ? -$signed(rt) : $signed(rt);
          s = r;
        end else begin
          c = r;
          s = neg ? -$signed(rt) : $signed(rt);
        end
      end
      if (item.slot < SLOTS) factor_store[item.slot] = {s[31:0], c[31:0]};
    end else if (item.slot < SLOTS) begin
      c = $signed(factor_store[item.slot][31:0]);
      s = $signed(factor_store[item.slot][63:32]);
    end
    res.first_result = round_clip(c * a - s * b, clipped);
    res.second_result = round_clip(s * a + c * b, clipped);
    res.saturated = clipped;
    return res;
  endfunction

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    gru_out_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) rotated_q.push_back(rotate_pair(in_data));
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = rotated_q.pop_front();
          if (want != out_data) begin
            if (want.first_result != out_data.first_result)
              $error("first_result expected %0d got %0d", want.first_result,
                     out_data.first_result);
            if (want.second_result != out_data.second_result)
              $error("second_result expected %0d got %0d", want.second_result,
                     out_data.second_result);
            if (want.saturated != out_data.saturated)
              $error("saturated expected %0d got %0d", want.saturated,
                     out_data.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### test/tb.sv
// Testbench top for the Givens rotation unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import gru_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  logic written [32];

  gru_if #(.T(gru_in_t))  in_ch ();
  gru_if #(.T(gru_out_t)) out_ch ();

  givens_rotation_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  gru_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls at random; a stall never runs on, since a low ready is always raised again.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 3) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 3) == 0) out_ch.ready <= ~out_ch.ready;
      else if (!out_ch.ready) out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pair(input logic kind, input logic [4:0] slot,
                           input logic [31:0] a, input logic [31:0] b);
    gru_in_t item;
    item.kind = kind;
    item.slot = slot;
    item.first_value = a;
    item.second_value = b;
    in_ch.data <= item;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind == KIND_GEN) written[slot] = 1'b1;
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(1, 6);
    in_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'd0;
      2: return $signed($urandom_range(0, 8'hff)) - 128;
      3: return ($urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000) * $urandom_range(1, 9);
      default: return $urandom();
    endcase
  endfunction

  task automatic pick_read_slot(output logic [4:0] slot);
    slot = 5'($urandom_range(0, 31));
    while (!written[slot]) slot = slot + 5'd1;
  endtask

  initial begin
    logic [4:0] slot;
    int burst;
    int sent;
    foreach (written[i]) written[i] = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero second value, extremes, both orderings of magnitude, reuse.
    send_pair(KIND_GEN, 5'd0, 32'h0001_0000, 32'd0);
    send_pair(KIND_GEN, 5'd31, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(KIND_GEN, 5'd1, 32'h8000_0000, 32'h8000_0000);
    send_pair(KIND_GEN, 5'd2, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(KIND_GEN, 5'd3, 32'd0, 32'hffff_0000);
    send_pair(KIND_GEN, 5'd4, 32'h0003_0000, 32'h0004_0000);
    send_pair(KIND_GEN, 5'd5, 32'hfffd_0000, 32'h0004_0000);
    send_pair(KIND_GEN, 5'd6, 32'h0000_0001, 32'h8000_0000);
    send_pair(KIND_GEN, 5'd7, 32'h7fff_ffff, 32'h0000_0001);
    send_pair(KIND_GEN, 5'd8, 32'h8000_0000, 32'd0);
    idle_gap();
    send_pair(1'b1, 5'd31, 32'h7fff_ffff, 32'h8000_0000);
    send_pair(1'b1, 5'd31, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(1'b1, 5'd5, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(1'b1, 5'd2, 32'h8000_0000, 32'h8000_0000);
    send_pair(1'b1, 5'd0, 32'hffff_ffff, 32'h0000_0001);
    send_pair(1'b1, 5'd4, 32'd0, 32'd0);
    send_pair(1'b1, 5'd3, 32'h1234_5678, 32'hedcb_a987);

    // Hold off until the block has drained once.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    sent = 0;
    while (sent < 450) begin
      burst = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(1, 8);
      repeat (burst) begin
        if ($urandom_range(0, 2) == 0) begin
          pick_read_slot(slot);
          send_pair(1'b1, slot, pick_value(), pick_value());
        end else begin
          send_pair(KIND_GEN, 5'($urandom_range(0, 31)), pick_value(), pick_value());
        end
        sent++;
      end
      idle_gap();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### filelist.f
design/gru_pkg.sv
design/gru_if.sv
design/gru_ctrl.sv
design/gru_dp.sv
design/givens_rotation_unit.sv
test/gru_checker.sv
test/tb.sv
